[rtl/rau_pkg.sv]
`default_nettype none

package rau_pkg;

  // operand field width and full cross-product magnitude width
  localparam int FLD_W = 32;
  localparam int DEN_W = 31;
  localparam int MAG_W = 64;
  localparam int CNT_W = $clog2(MAG_W);

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // largest magnitudes that fit a signed 32-bit numerator
  localparam logic [MAG_W-1:0] NUM_POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [MAG_W-1:0] NUM_NEG_MAX = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [FLD_W-1:0] a_num;
    logic signed [FLD_W-1:0] a_den;
    logic signed [FLD_W-1:0] b_num;
    logic signed [FLD_W-1:0] b_den;
  } rau_cmd_t;

  typedef struct packed {
    logic signed [FLD_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic [1:0]              status;
  } rau_result_t;

  // top-level sequencer
  typedef enum logic [2:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_GCD, S_DIV, S_FIN
  } rau_state_t;

  // binary GCD engine
  typedef enum logic [1:0] {
    G_IDLE, G_TWOS, G_LOOP
  } rau_gcd_state_t;

  // restoring divider
  typedef enum logic {
    D_IDLE, D_RUN
  } rau_div_state_t;

  // magnitude of a two's complement field (-2^31 gives 2^31)
  function automatic logic [FLD_W-1:0] mag32(input logic [FLD_W-1:0] v);
    logic [FLD_W-1:0] neg_v;
    neg_v = (~v) + 1'b1;
    return v[FLD_W-1] ? neg_v : v;
  endfunction

endpackage

`default_nettype wire

[rtl/rau_mul.sv]
`default_nettype none

// 32x32 unsigned multiplier with registered product
module rau_mul import rau_pkg::*; (
  input  logic             clk,
  input  logic [FLD_W-1:0] x,
  input  logic [FLD_W-1:0] y,
  output logic [MAG_W-1:0] prod
);

  logic [MAG_W-1:0] prod_c;

  assign prod_c = MAG_W'(x) * MAG_W'(y);

  always_ff @(posedge clk) begin
    prod <= prod_c;
  end

endmodule

`default_nettype wire

[rtl/rau_gcd.sv]
`default_nettype none

// Binary GCD over 64-bit magnitudes: one shift or one subtract-and-shift per cycle.
// Both inputs must be nonzero.
module rau_gcd import rau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] u_in,
  input  logic [MAG_W-1:0] v_in,
  output logic             done,
  output logic [MAG_W-1:0] g
);

  rau_gcd_state_t   state, state_next;
  logic [MAG_W-1:0] u, u_next;
  logic [MAG_W-1:0] v, v_next;
  logic [CNT_W-1:0] k, k_next;
  logic             u_gt;
  logic [MAG_W-1:0] sub_a, sub_b, diff;

  // shared compare and subtract
  assign u_gt  = u > v;
  assign sub_a = u_gt ? u : v;
  assign sub_b = u_gt ? v : u;
  assign diff  = sub_a - sub_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      G_IDLE: if (start) state_next = G_TWOS;
      G_TWOS: if (u[0] || v[0]) state_next = G_LOOP;
      G_LOOP: if (u == v) state_next = G_IDLE;
      default: state_next = G_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    unique case (state)
      G_IDLE: begin
        if (start) begin
          u_next = u_in;
          v_next = v_in;
          k_next = '0;
        end
      end
      G_TWOS: begin
        // strip common factors of two
        if (!u[0] && !v[0]) begin
          u_next = u >> 1;
          v_next = v >> 1;
          k_next = k + 1'b1;
        end
      end
      G_LOOP: begin
        if (u != v) begin
          if (!u[0]) begin
            u_next = u >> 1;
          end else if (!v[0]) begin
            v_next = v >> 1;
          end else if (u_gt) begin
            u_next = diff >> 1;   // odd minus odd is even
          end else begin
            v_next = diff >> 1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == G_LOOP) && (u == v);
    end
  end

  always_ff @(posedge clk) begin
    u <= u_next;
    v <= v_next;
    k <= k_next;
    if (state == G_LOOP && u == v) begin
      g <= u << k;
    end
  end

endmodule

`default_nettype wire

[rtl/rau_div.sv]
`default_nettype none

// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0][MAG_W-1:0] dvd,
  input  logic [MAG_W-1:0]      dvs,
  output logic                  done,
  output logic [1:0][MAG_W-1:0] quo
);

  rau_div_state_t        state, state_next;
  logic [CNT_W-1:0]      cnt;
  logic                  last;
  logic [MAG_W-1:0]      dvs_r;
  logic [1:0][MAG_W-1:0] rem, rem_next, quo_next;
  logic [1:0][MAG_W:0]   rs;
  logic [1:0]            ge;

  assign last = (cnt == CNT_W'(MAG_W - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (start) state_next = D_RUN;
      D_RUN:  if (last) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  // per-lane shift, compare and subtract
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rs[i]       = {rem[i], quo[i][MAG_W-1]};
      ge[i]       = rs[i] >= {1'b0, dvs_r};
      rem_next[i] = ge[i] ? MAG_W'(rs[i] - {1'b0, dvs_r}) : rs[i][MAG_W-1:0];
      quo_next[i] = {quo[i][MAG_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == D_RUN) && last;
    end
  end

  always_ff @(posedge clk) begin
    if (state == D_IDLE && start) begin
      quo   <= dvd;
      rem   <= '0;
      dvs_r <= dvs;
      cnt   <= '0;
    end else if (state == D_RUN) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/rational_arith_unit.sv]
`default_nettype none

// Channel   Ports                      Moves
// -------   -------------------------  ------------------------------------------
// request   start, busy, cmd           op and two fractions, taken on start && !busy
// result    done, result               reduced fraction and status, one-cycle strobe
//
// The time from accept to done grows with the number of binary-GCD steps; the GCD
// loop and the 64-step divider set it. A request with a zero denominator or a zero
// divisor goes from idle straight to the final state.
// busy is high from accept until the result is registered; done then pulses once
// while the next request may already be accepted.
// Reset (rst, synchronous) returns the sequencer to idle and drops busy and done.
// The receiver cannot stall: done is high for exactly one cycle; result holds until the next request finishes.
module rational_arith_unit import rau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  rau_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output rau_result_t result
);

  rau_state_t       state, state_next;
  logic [1:0]       op_r;
  logic [FLD_W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic             an_neg, ad_neg, bn_neg, bd_neg;
  logic [1:0]       status_r;
  logic             zero_r;
  logic [MAG_W-1:0] nmag, dmag;
  logic             nneg, dneg;
  logic             cmd_err;

  logic [FLD_W-1:0] mul_x, mul_y;
  logic [MAG_W-1:0] prod;
  logic             sign0, sign1, t2neg, addsub;
  logic [MAG_W-1:0] sum_mag;
  logic             sum_neg;

  logic             gcd_start, gcd_done;
  logic [MAG_W-1:0] gcd_g;
  logic             div_start, div_done;
  logic [1:0][MAG_W-1:0] div_dvd, div_quo;

  logic             res_neg, ovf;
  rau_result_t      result_next;

  // request checks
  assign cmd_err = (cmd.a_den == '0) || (cmd.b_den == '0) ||
                   ((cmd.op == OP_DIV) && (cmd.b_num == '0));

  assign addsub = (op_r == OP_ADD) || (op_r == OP_SUB);
  assign sign0  = an_neg ^ ((op_r == OP_MUL) ? bn_neg : bd_neg);
  assign sign1  = ad_neg ^ ((op_r == OP_DIV) ? bn_neg : bd_neg);
  assign t2neg  = ad_neg ^ bn_neg ^ (op_r == OP_SUB);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = cmd_err ? S_FIN : S_MUL0;
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_SUM;
      S_SUM:  state_next = (sum_mag == '0) ? S_FIN : S_GCD;
      S_GCD:  if (gcd_done) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and unit starts
  always_comb begin
    mul_x     = ad_mag;
    mul_y     = bn_mag;
    gcd_start = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_MUL0: begin
        mul_x = an_mag;
        mul_y = (op_r == OP_MUL) ? bn_mag : bd_mag;
      end
      S_MUL1: begin
        mul_x = ad_mag;
        mul_y = (op_r == OP_DIV) ? bn_mag : bd_mag;
      end
      S_SUM:  gcd_start = (sum_mag != '0);
      S_GCD:  div_start = gcd_done;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // signed-magnitude sum of the cross products (add and subtract only)
  always_comb begin
    sum_mag = nmag;
    sum_neg = nneg;
    if (addsub) begin
      if (nneg == t2neg) begin
        sum_mag = nmag + prod;
      end else if (nmag >= prod) begin
        sum_mag = nmag - prod;
      end else begin
        sum_mag = prod - nmag;
        sum_neg = t2neg;
      end
    end
  end

  // final range check and result format
  assign res_neg = nneg ^ dneg;
  assign ovf = (div_quo[1][MAG_W-1:DEN_W] != '0) ||
               (res_neg ? (div_quo[0] > NUM_NEG_MAX) : (div_quo[0] > NUM_POS_MAX));

  always_comb begin
    result_next.res_num = '0;
    result_next.res_den = DEN_W'(1);
    result_next.status  = status_r;
    if (status_r == ST_OK && !zero_r) begin
      if (ovf) begin
        result_next.status = ST_OVF;
      end else begin
        result_next.res_num = res_neg ? $signed(FLD_W'(0) - div_quo[0][FLD_W-1:0])
                                      : $signed(div_quo[0][FLD_W-1:0]);
        result_next.res_den = div_quo[1][DEN_W-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_r     <= cmd.op;
      an_mag   <= mag32(cmd.a_num);
      ad_mag   <= mag32(cmd.a_den);
      bn_mag   <= mag32(cmd.b_num);
      bd_mag   <= mag32(cmd.b_den);
      an_neg   <= cmd.a_num[FLD_W-1];
      ad_neg   <= cmd.a_den[FLD_W-1];
      bn_neg   <= cmd.b_num[FLD_W-1];
      bd_neg   <= cmd.b_den[FLD_W-1];
      status_r <= cmd_err ? ST_ZERO : ST_OK;
      zero_r   <= 1'b0;
    end
    if (state == S_MUL1) begin
      nmag <= prod;
      nneg <= sign0;
    end
    if (state == S_MUL2) begin
      dmag <= prod;
      dneg <= sign1;
    end
    if (state == S_SUM) begin
      nmag   <= sum_mag;
      nneg   <= sum_neg;
      zero_r <= (sum_mag == '0);
    end
    if (state == S_FIN) begin
      result <= result_next;
    end
  end

  rau_mul u_mul (
    .clk  (clk),
    .x    (mul_x),
    .y    (mul_y),
    .prod (prod)
  );

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .u_in  (sum_mag),
    .v_in  (dmag),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  assign div_dvd = {dmag, nmag};

  rau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (gcd_g),
    .done  (div_done),
    .quo   (div_quo)
  );

  // a result strobe follows the final state only
  a_done_from_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("result strobe without final state");

  // failed results read as 0/1
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> (result.res_num == '0) && (result.res_den == 1))
    else $error("failed result is not 0/1");

  // a good result never has a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_OK) |-> (result.res_den != '0))
    else $error("zero denominator in good result");

  // GCD completes only while the sequencer waits for it
  a_gcd_in_state: assert property (@(posedge clk) disable iff (rst)
    gcd_done |-> (state == S_GCD))
    else $error("GCD done outside GCD state");

  // divider completes only while the sequencer waits for it
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside divide state");

endmodule

`default_nettype wire

[dv/rational_arith_unit_tb.sv]
`timescale 1ns / 1ps

module rational_arith_unit_tb;
  import rau_pkg::*;

  localparam logic [FLD_W-1:0] FLD_MAX = 32'h7FFF_FFFF;
  localparam logic [FLD_W-1:0] FLD_MIN = 32'h8000_0000;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 250;

  // sign-magnitude value with room for a full cross product
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } signmag_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  rau_cmd_t    cmd = '0;
  logic        busy;
  logic        done;
  rau_result_t result;

  rau_result_t queued_fractions[$];
  int          failures = 0;
  int          idle_cycles = 0;
  int          max_gap = 6;

  rational_arith_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Fraction arithmetic
  // ---------------------------------------------------------------------------

  function automatic signmag_t to_signmag(input logic [FLD_W-1:0] v);
    signmag_t r;
    r.neg = v[FLD_W-1];
    r.mag = {32'd0, v[FLD_W-1] ? (~v + 32'd1) : v};
    return r;
  endfunction

  function automatic signmag_t signmag_mul(input signmag_t x, input signmag_t y);
    signmag_t r;
    r.neg = x.neg ^ y.neg;
    r.mag = x.mag * y.mag;
    return r;
  endfunction

  // exact result of one request, reduced to lowest terms
  function automatic rau_result_t rational_result(input rau_cmd_t c);
    signmag_t    an, ad, bn, bd, nm, dn, t1, t2;
    logic [MAG_W-1:0] g, x, r;
    logic        neg;
    rau_result_t res;
    res.res_num = '0;
    res.res_den = 31'd1;
    res.status  = ST_OK;
    an = to_signmag(c.a_num);
    ad = to_signmag(c.a_den);
    bn = to_signmag(c.b_num);
    bd = to_signmag(c.b_den);
    if (ad.mag == 0 || bd.mag == 0 || (c.op == OP_DIV && bn.mag == 0)) begin
      res.status = ST_ZERO;
      return res;
    end
    case (c.op)
      OP_ADD, OP_SUB: begin
        t1 = signmag_mul(an, bd);
        t2 = signmag_mul(ad, bn);
        if (c.op == OP_SUB) t2.neg = !t2.neg;
        if (t1.neg == t2.neg) begin
          nm.neg = t1.neg;
          nm.mag = t1.mag + t2.mag;
        end else if (t1.mag >= t2.mag) begin
          nm.neg = t1.neg;
          nm.mag = t1.mag - t2.mag;
        end else begin
          nm.neg = t2.neg;
          nm.mag = t2.mag - t1.mag;
        end
        dn = signmag_mul(ad, bd);
      end
      OP_MUL: begin
        nm = signmag_mul(an, bn);
        dn = signmag_mul(ad, bd);
      end
      default: begin
        nm = signmag_mul(an, bd);
        dn = signmag_mul(ad, bn);
      end
    endcase
    if (nm.mag == 0) return res;
    // Euclid
    g = nm.mag;
    x = dn.mag;
    while (x != 0) begin
      r = g % x;
      g = x;
      x = r;
    end
    nm.mag = nm.mag / g;
    dn.mag = dn.mag / g;
    neg = nm.neg ^ dn.neg;
    if (dn.mag > 64'h7FFF_FFFF || (neg ? nm.mag > NUM_NEG_MAX : nm.mag > NUM_POS_MAX)) begin
      res.status = ST_OVF;
      return res;
    end
    x = neg ? (~nm.mag + 64'd1) : nm.mag;
    res.res_num = x[FLD_W-1:0];
    res.res_den = dn.mag[DEN_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rau_cmd_t make_cmd(input logic [1:0] op, input logic [FLD_W-1:0] an,
                                        input logic [FLD_W-1:0] ad, input logic [FLD_W-1:0] bn,
                                        input logic [FLD_W-1:0] bd);
    rau_cmd_t c;
    c.op    = op;
    c.a_num = an;
    c.a_den = ad;
    c.b_num = bn;
    c.b_den = bd;
    return c;
  endfunction

  // 0 small, 1 medium, 2 full range, 3 boundary values
  function automatic int rand_kind();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 70) return 1;
    if (p < 85) return 2;
    return 3;
  endfunction

  function automatic logic [FLD_W-1:0] rand_value(input int kind);
    logic [FLD_W-1:0] v;
    int k;
    k = kind;
    if ($urandom_range(0, 9) == 0) k = rand_kind();
    case (k)
      0: begin
        v = $urandom_range(0, 40);
        v = v - 32'd20;
      end
      1: begin
        v = $urandom_range(0, 131072);
        v = v - 32'd65536;
      end
      2: v = $urandom();
      default: begin
        case ($urandom_range(0, 6))
          0: v = 32'd0;
          1: v = 32'd1;
          2: v = 32'hFFFF_FFFF;
          3: v = FLD_MAX;
          4: v = FLD_MIN;
          5: v = FLD_MAX - 32'd1;
          default: v = FLD_MIN + 32'd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // clean requests keep both denominators and any divisor nonzero
  function automatic rau_cmd_t rand_cmd(input bit clean);
    rau_cmd_t c;
    int k;
    k = rand_kind();
    c.op    = 2'($urandom_range(0, 3));
    c.a_num = rand_value(k);
    c.a_den = rand_value(k);
    c.b_num = rand_value(k);
    c.b_den = rand_value(k);
    if (clean) begin
      if (c.a_den == 0) c.a_den = 32'd1;
      if (c.b_den == 0) c.b_den = 32'hFFFF_FFFF;
      if (c.op == OP_DIV && c.b_num == 0) c.b_num = 32'd1;
    end
    return c;
  endfunction

  // one request: random gap, then hold start until accepted
  task automatic send_request(input rau_cmd_t c);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    queued_fractions.push_back(rational_result(c));
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (queued_fractions.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    max_gap = 6;
    send_request(make_cmd(OP_ADD, 1, 2, 1, 3));
    send_request(make_cmd(OP_SUB, 1, 2, 1, 2));                 // zero result
    send_request(make_cmd(OP_MUL, 6, 4, 2, 3));
    send_request(make_cmd(OP_DIV, 3, 4, -3, 8));
    send_request(make_cmd(OP_ADD, 5, 0, 1, 3));                 // left den zero
    send_request(make_cmd(OP_MUL, 5, 7, 1, 0));                 // right den zero
    send_request(make_cmd(OP_DIV, 5, 7, 0, 3));                 // divide by zero
    send_request(make_cmd(OP_ADD, 1, -2, 0, 5));                // negative den
    send_request(make_cmd(OP_MUL, -1, -1, 1, 1));
    send_request(make_cmd(OP_ADD, FLD_MAX, 1, 1, 1));           // numerator overflow
    send_request(make_cmd(OP_MUL, FLD_MIN, 1, -1, 1));          // +2^31 overflows
    send_request(make_cmd(OP_SUB, FLD_MIN, 1, 0, 1));           // -2^31 still fits
    send_request(make_cmd(OP_MUL, 1, 65536, 1, 32768));         // den 2^31 overflows
    send_request(make_cmd(OP_MUL, 1, 65536, 1, 32767));
    send_request(make_cmd(OP_DIV, FLD_MIN, FLD_MIN, FLD_MAX, FLD_MAX));
    send_request(make_cmd(OP_MUL, FLD_MIN, FLD_MAX, FLD_MIN, FLD_MAX));
    send_request(make_cmd(OP_ADD, FLD_MIN, FLD_MIN, FLD_MIN, FLD_MIN));
    send_request(make_cmd(OP_DIV, FLD_MAX, 1, FLD_MIN, 1));
    send_request(make_cmd(OP_DIV, 1, FLD_MIN, -1, 1));
    send_request(make_cmd(OP_SUB, -1, FLD_MAX, 1, FLD_MIN));
    send_request(make_cmd(OP_ADD, 0, -7, 0, 3));
    send_request(make_cmd(OP_DIV, 0, 5, 3, 0));
    send_request(make_cmd(OP_DIV, -1, -1, -1, -1));
    send_request(make_cmd(OP_SUB, FLD_MAX, FLD_MIN, FLD_MIN, FLD_MAX));
  endtask

  task automatic test_random_mixed(input int n);
    for (int i = 0; i < n; i++) begin
      // every third stretch runs back to back
      max_gap = ((i / 64) % 3 == 2) ? 0 : 6;
      send_request(rand_cmd($urandom_range(0, 19) != 0));
    end
  endtask

  // short requests: zero dens, zero divisor, zero results
  task automatic test_zero_cases(input int n);
    rau_cmd_t c;
    for (int i = 0; i < n; i++) begin
      max_gap = ((i / 32) % 2 == 1) ? 0 : 6;
      c = rand_cmd(1'b1);
      case ($urandom_range(0, 4))
        0: c.a_den = '0;
        1: c.b_den = '0;
        2: begin
          c.op    = OP_DIV;
          c.b_num = '0;
        end
        3: begin
          c.op    = OP_MUL;
          c.a_num = '0;
        end
        default: begin
          c.op    = OP_SUB;
          c.b_num = c.a_num;
          c.b_den = c.a_den;
        end
      endcase
      send_request(c);
    end
  endtask

  // operands with large common factors so the reduction does real work
  task automatic test_common_factors(input int n);
    rau_cmd_t c;
    int m1, m2;
    for (int i = 0; i < n; i++) begin
      max_gap = 6;
      m1 = $urandom_range(1, 1 << 20);
      m2 = $urandom_range(1, 1 << 20);
      c.op    = 2'($urandom_range(0, 3));
      c.a_num = ($urandom_range(0, 80) - 40) * m1;
      c.a_den = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1) * m1;
      c.b_num = ($urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1)) * m2;
      c.b_den = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1) * m2;
      send_request(c);
    end
  endtask

  // sender stops until every outstanding result has come back
  task automatic test_pause_drain();
    max_gap = 3;
    for (int i = 0; i < 10; i++) send_request(rand_cmd(1'b1));
    hold_until_drained();
    for (int i = 0; i < 10; i++) send_request(rand_cmd(1'b1));
    hold_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    rau_result_t want;
    if (done) begin
      if (queued_fractions.size() == 0) begin
        $error("unexpected result: res_num %0d res_den %0d status %0d",
               result.res_num, result.res_den, result.status);
        failures++;
      end else begin
        want = queued_fractions.pop_front();
        if (result.res_num !== want.res_num) begin
          $error("res_num: expected %0d, got %0d", want.res_num, result.res_num);
          failures++;
        end
        if (result.res_den !== want.res_den) begin
          $error("res_den: expected %0d, got %0d", want.res_den, result.res_den);
          failures++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          failures++;
        end
      end
    end
  end

  // watchdog: cycles with neither a request accepted nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mixed(900);
    test_pause_drain();
    test_zero_cases(150);
    test_common_factors(160);
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
